// ===== rtl/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// shared types and constants of the link failsafe supervisor
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_CONNECT    = 2'd1,
    CMD_DISCONNECT = 2'd2,
    CMD_PACKET     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_FORWARD    = 3'd1,
    ST_INVALID    = 3'd2,
    ST_WRONG_LINK = 3'd3,
    ST_STALE      = 3'd4
  } status_t;

  // configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_ALIVE   = 1'b1;

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  ALIVE_RST   = 8'd10;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_DATA_W  = 16;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  link_id;
    logic        packet_valid;
    logic [15:0] session;
    logic [15:0] sequence_req;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        forward;
    logic        send_alive;
    logic        stop_emit;
    logic [15:0] stop_session;
    logic [15:0] stop_sequence;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/lfs_core.sv =====
// ----------------------------------------------------------------------------
// lfs_core
// link state registers, config registers and per-item decision logic
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [lfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               en,
  input  wire lfs_pkg::item_t                     item,
  output lfs_pkg::result_t                        res
);

  logic [15:0] timeout_r;
  logic [7:0]  interval_r;

  logic [7:0]  bound_link_r,  bound_link_nxt;
  logic        link_bound_r,  link_bound_nxt;
  logic [15:0] session_r,     session_nxt;
  logic [15:0] last_seq_r,    last_seq_nxt;
  logic        seen_r,        seen_nxt;
  logic        fired_r,       fired_nxt;
  logic [15:0] elapsed_r,     elapsed_nxt;
  logic [7:0]  phase_r,       phase_nxt;

  logic [15:0] elapsed_inc;
  logic [15:0] seq_diff;
  logic        seq_newer;
  logic [8:0]  phase_inc;
  logic        fire;

  assign elapsed_inc = (elapsed_r == lfs_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign seq_diff    = item.sequence_req - last_seq_r;
  assign seq_newer   = (seq_diff != 16'd0) && !seq_diff[15];
  assign phase_inc   = {1'b0, phase_r} + 9'd1;

  always_comb begin
    bound_link_nxt = bound_link_r;
    link_bound_nxt = link_bound_r;
    session_nxt    = session_r;
    last_seq_nxt   = last_seq_r;
    seen_nxt       = seen_r;
    fired_nxt      = fired_r;
    elapsed_nxt    = elapsed_r;
    phase_nxt      = phase_r;
    fire           = 1'b0;
    res.status        = lfs_pkg::ST_NONE;
    res.forward       = 1'b0;
    res.send_alive    = 1'b0;
    res.stop_emit     = 1'b0;
    res.stop_session  = 16'd0;
    res.stop_sequence = 16'd0;
    case (item.command)
      lfs_pkg::CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (seen_r && !fired_r && (elapsed_inc > timeout_r)) begin
          fire = 1'b1;
        end
      end
      lfs_pkg::CMD_CONNECT: begin
        bound_link_nxt = item.link_id;
        link_bound_nxt = 1'b1;
        seen_nxt       = 1'b0;
        fired_nxt      = 1'b0;
        phase_nxt      = 8'd0;
        elapsed_nxt    = 16'd0;
      end
      lfs_pkg::CMD_DISCONNECT: begin
        if (link_bound_r && (bound_link_r == item.link_id)) begin
          link_bound_nxt = 1'b0;
          if (seen_r && !fired_r) begin
            fire = 1'b1;
          end
        end
      end
      lfs_pkg::CMD_PACKET: begin
        if (!item.packet_valid) begin
          res.status = lfs_pkg::ST_INVALID;
        end else if (!link_bound_r || (bound_link_r != item.link_id)) begin
          res.status = lfs_pkg::ST_WRONG_LINK;
        end else if (seen_r && (item.session == session_r) && !seq_newer) begin
          res.status = lfs_pkg::ST_STALE;
        end else begin
          res.status     = lfs_pkg::ST_FORWARD;
          res.forward    = 1'b1;
          res.send_alive = !seen_r;
          if (phase_inc >= {1'b0, interval_r}) begin
            phase_nxt      = 8'd0;
            res.send_alive = 1'b1;
          end else begin
            phase_nxt = phase_inc[7:0];
          end
          session_nxt  = item.session;
          last_seq_nxt = item.sequence_req;
          elapsed_nxt  = 16'd0;
          seen_nxt     = 1'b1;
          fired_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (fire) begin
      fired_nxt         = 1'b1;
      res.stop_emit     = 1'b1;
      res.stop_session  = session_r;
      res.stop_sequence = last_seq_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= lfs_pkg::TIMEOUT_RST;
      interval_r <= lfs_pkg::ALIVE_RST;
    end else if (cfg_we) begin
      if (cfg_index == lfs_pkg::REG_TIMEOUT) begin
        timeout_r <= cfg_wdata[15:0];
      end else if (cfg_index == lfs_pkg::REG_ALIVE) begin
        interval_r <= cfg_wdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_link_r <= 8'd0;
      link_bound_r <= 1'b0;
      session_r    <= 16'd0;
      last_seq_r   <= 16'd0;
      seen_r       <= 1'b0;
      fired_r      <= 1'b0;
      elapsed_r    <= 16'd0;
      phase_r      <= 8'd0;
    end else if (en) begin
      bound_link_r <= bound_link_nxt;
      link_bound_r <= link_bound_nxt;
      session_r    <= session_nxt;
      last_seq_r   <= last_seq_nxt;
      seen_r       <= seen_nxt;
      fired_r      <= fired_nxt;
      elapsed_r    <= elapsed_nxt;
      phase_r      <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/link_failsafe_supervisor.sv =====
// ----------------------------------------------------------------------------
// link_failsafe_supervisor
// watches one control link: binds it on connect, filters its packets,
// raises alive notices and a single emergency stop on silence or disconnect.
//
// in_ channel carries one event per item (tick, connect, disconnect, packet),
// out_ channel returns exactly one result item per event, in order.
// cfg_ port writes timeout_ms (index 0) and alive_interval (index 1); the user must
// write them only while idle, the block does not enforce it. an item is held in
// the input register, then the decision logic updates the link state and loads
// the result register, which drives out_tvalid. one item per cycle is taken
// sustained while out_tready stays high. lfs_core updates its link state at the
// same edge as the result register is loaded, which sets the rate.
// reset clears the link state, empties both registers and restores the
// config defaults (500 ms, interval 10).
// when out_tready is low the result register holds, the input register fills,
// and in_tready drops until the result is taken; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module link_failsafe_supervisor (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // link_id[7:0], packet_valid[8], session[24:9], sequence_req[40:25]
  input  wire logic [lfs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[1:0]
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // forward[0], send_alive[1], stop_emit[2], stop_session[18:3],
  // stop_sequence[34:19]
  output logic [lfs_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // status[2:0]
  output logic [2:0]                             out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [lfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic             in_v_r;
  lfs_pkg::item_t   item_r;
  logic             out_v_r;
  lfs_pkg::result_t res_r;
  lfs_pkg::result_t res_nxt;
  logic             advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command      <= lfs_pkg::cmd_t'(in_tuser);
      item_r.link_id      <= in_tdata[7:0];
      item_r.packet_valid <= in_tdata[8];
      item_r.session      <= in_tdata[24:9];
      item_r.sequence_req <= in_tdata[40:25];
    end
  end

  lfs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .en        (advance),
    .item      (item_r),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {5'd0, res_r.stop_sequence, res_r.stop_session,
                       res_r.stop_emit, res_r.send_alive, res_r.forward};

endmodule

`default_nettype wire

// ===== rtl/lfs_checker.sv =====
// ----------------------------------------------------------------------------
// lfs_checker
// port-level checks of the result stream of link_failsafe_supervisor
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lfs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic [2:0]                        out_tuser
);

  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // forward flag agrees with status
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (out_tuser == lfs_pkg::ST_FORWARD))
    else $error("forward and status disagree");

  // alive only with a forwarded packet
  a_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("alive without forward");

  // stop only on non-packet events, stop fields zero otherwise
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] ? (out_tuser == lfs_pkg::ST_NONE)
                                 : (out_tdata[34:3] == 32'd0)))
    else $error("stop fields inconsistent");

endmodule

bind link_failsafe_supervisor lfs_checker u_lfs_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// testbench of link_failsafe_supervisor. streams tick, connect, disconnect and
// packet items into the block, works out each expected result with its own
// copy of the link state, and compares every returned item field by field.
// covers the reset defaults, every packet verdict, sequence wrap, the single
// emergency stop, timeout register extremes and back pressure.
// ----------------------------------------------------------------------------
module tb;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lfs_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [lfs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]                      out_tuser;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [lfs_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  // predicted registers and link state
  logic [15:0] lim_ms;
  logic [7:0]  beat_every;
  logic [7:0]  peer_id;
  logic        peer_up;
  logic [15:0] sess_now;
  logic [15:0] seq_now;
  logic        heard;
  logic        tripped;
  logic [15:0] quiet_ms;
  logic [7:0]  beat_cnt;

  // traffic source state
  logic [7:0]  drv_link = 8'h42;
  logic [15:0] drv_sess = 16'h1000;
  logic [15:0] drv_seq  = 16'hFFF0;

  lfs_pkg::result_t results_due[$];
  int      mismatches = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  link_failsafe_supervisor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #100000000;
    $display("tb failed");
    $finish;
  end

  function automatic lfs_pkg::result_t supervise(lfs_pkg::item_t e);
    lfs_pkg::result_t r;
    logic [15:0]      gap;
    logic [8:0]       nxt;
    r = '0;
    r.status = lfs_pkg::ST_NONE;
    case (e.command)
      lfs_pkg::CMD_TICK: begin
        if (quiet_ms != lfs_pkg::ELAPSED_MAX) quiet_ms = quiet_ms + 16'd1;
        if (heard && !tripped && quiet_ms > lim_ms) begin
          tripped = 1'b1;
          r.stop_emit = 1'b1;
          r.stop_session = sess_now;
          r.stop_sequence = seq_now + 16'd1;
        end
      end
      lfs_pkg::CMD_CONNECT: begin
        peer_id = e.link_id;
        peer_up = 1'b1;
        heard = 1'b0;
        tripped = 1'b0;
        beat_cnt = 8'd0;
        quiet_ms = 16'd0;
      end
      lfs_pkg::CMD_DISCONNECT: begin
        if (peer_up && peer_id == e.link_id) begin
          peer_up = 1'b0;
          if (heard && !tripped) begin
            tripped = 1'b1;
            r.stop_emit = 1'b1;
            r.stop_session = sess_now;
            r.stop_sequence = seq_now + 16'd1;
          end
        end
      end
      default: begin
        gap = e.sequence_req - seq_now;
        if (!e.packet_valid) begin
          r.status = lfs_pkg::ST_INVALID;
        end else if (!peer_up || peer_id != e.link_id) begin
          r.status = lfs_pkg::ST_WRONG_LINK;
        end else if (heard && e.session == sess_now && (gap == 16'd0 || gap[15])) begin
          r.status = lfs_pkg::ST_STALE;
        end else begin
          // first packet of a watch always gets an alive notice
          r.send_alive = !heard;
          nxt = {1'b0, beat_cnt} + 9'd1;
          if (nxt >= {1'b0, beat_every}) begin
            beat_cnt = 8'd0;
            r.send_alive = 1'b1;
          end else begin
            beat_cnt = nxt[7:0];
          end
          sess_now = e.session;
          seq_now = e.sequence_req;
          quiet_ms = 16'd0;
          heard = 1'b1;
          tripped = 1'b0;
          r.status = lfs_pkg::ST_FORWARD;
          r.forward = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic lfs_pkg::item_t make_item(lfs_pkg::cmd_t c, logic [7:0] l, logic v,
                                               logic [15:0] s, logic [15:0] q);
    lfs_pkg::item_t e;
    e.command = c;
    e.link_id = l;
    e.packet_valid = v;
    e.session = s;
    e.sequence_req = q;
    return e;
  endfunction

  function automatic lfs_pkg::item_t spare(lfs_pkg::cmd_t c);
    return make_item(c, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic lfs_pkg::item_t next_traffic();
    lfs_pkg::item_t e;
    int             pick;
    e = spare(lfs_pkg::CMD_TICK);
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      if (pick >= 48) begin
        drv_sess = 16'($urandom);
        drv_seq = 16'($urandom);
      end else if (pick < 42) begin
        drv_seq = drv_seq + 16'($urandom_range(1, 40));
      end
      e = make_item(lfs_pkg::CMD_PACKET, drv_link, 1'b1, drv_sess, drv_seq);
      if (pick >= 42 && pick < 48) begin
        e.sequence_req = $urandom_range(0, 1) ? drv_seq - 16'($urandom_range(0, 50))
                                              : drv_seq ^ 16'h8000;
      end
    end else if (pick < 78) begin
      e.command = lfs_pkg::CMD_TICK;
    end else if (pick < 82) begin
      if ($urandom_range(0, 3) == 0) drv_link = 8'($urandom);
      e.command = lfs_pkg::CMD_CONNECT;
      e.link_id = drv_link;
    end else if (pick < 86) begin
      e.command = lfs_pkg::CMD_DISCONNECT;
      if ($urandom_range(0, 2) != 0) e.link_id = drv_link;
    end else begin
      e.command = lfs_pkg::cmd_t'(2'($urandom_range(0, 3)));
    end
    return e;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
  endtask

  task automatic offer_event(lfs_pkg::item_t e);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= e.command;
    in_tdata <= {7'd0, e.sequence_req, e.session, e.packet_valid, e.link_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    results_due.push_back(supervise(e));
  endtask

  // stop offering and wait for the block to drain
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (results_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == lfs_pkg::REG_TIMEOUT) lim_ms = val;
    else beat_every = val[7:0];
  endtask

  task automatic check_result();
    lfs_pkg::result_t want;
    if (results_due.size() == 0) begin
      flag_mismatch("item with none due", {29'd0, out_tuser}, 32'd0);
    end else begin
      want = results_due.pop_front();
      if (out_tuser !== want.status)
        flag_mismatch("status", 32'(out_tuser), 32'(want.status));
      if (out_tdata[0] !== want.forward)
        flag_mismatch("forward", 32'(out_tdata[0]), 32'(want.forward));
      if (out_tdata[1] !== want.send_alive)
        flag_mismatch("send_alive", 32'(out_tdata[1]), 32'(want.send_alive));
      if (out_tdata[2] !== want.stop_emit)
        flag_mismatch("stop_emit", 32'(out_tdata[2]), 32'(want.stop_emit));
      if (out_tdata[18:3] !== want.stop_session)
        flag_mismatch("stop_session", 32'(out_tdata[18:3]), 32'(want.stop_session));
      if (out_tdata[34:19] !== want.stop_sequence)
        flag_mismatch("stop_sequence", 32'(out_tdata[34:19]), 32'(want.stop_sequence));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) check_result();
  end

  // result side: random stalls, one long hold on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_after_reset();
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h00, 1'b1, 16'h0000, 16'h0000));
    offer_event(spare(lfs_pkg::CMD_TICK));
    offer_event(make_item(lfs_pkg::CMD_DISCONNECT, 8'h00, 1'b1, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_CONNECT, 8'hFF, 1'b0, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h00, 1'b1, 16'hFFFF, 16'h0001));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'hFFFF, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'hFFFF, 16'h8000));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'hFFFF, 16'h7FFF));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_DISCONNECT, 8'h00, 1'b0, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_DISCONNECT, 8'hFF, 1'b0, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_DISCONNECT, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'hFF, 1'b1, 16'h0000, 16'h0001));
    // default interval and timeout
    offer_event(make_item(lfs_pkg::CMD_CONNECT, 8'h5A, 1'b0, 16'h0000, 16'h0000));
    for (int i = 0; i < 11; i++) begin
      offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h5A, 1'b1, 16'h2222, 16'(i)));
    end
    repeat (502) offer_event(spare(lfs_pkg::CMD_TICK));
  endtask

  task automatic test_stop_rules();
    settle();
    write_reg(lfs_pkg::REG_TIMEOUT, 16'd0);
    write_reg(lfs_pkg::REG_ALIVE, 16'd0);
    offer_event(make_item(lfs_pkg::CMD_CONNECT, 8'h00, 1'b1, 16'h0000, 16'h0000));
    offer_event(spare(lfs_pkg::CMD_TICK));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h00, 1'b1, 16'h1234, 16'h0010));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h00, 1'b1, 16'h1234, 16'h0011));
    repeat (2) offer_event(spare(lfs_pkg::CMD_TICK));
    offer_event(make_item(lfs_pkg::CMD_DISCONNECT, 8'h00, 1'b0, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_CONNECT, 8'h00, 1'b0, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h00, 1'b1, 16'h1234, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_DISCONNECT, 8'h00, 1'b0, 16'h0000, 16'h0000));
    settle();
    write_reg(lfs_pkg::REG_TIMEOUT, 16'd3);
    write_reg(lfs_pkg::REG_ALIVE, 16'd255);
    offer_event(make_item(lfs_pkg::CMD_CONNECT, 8'h81, 1'b0, 16'h0000, 16'h0000));
    for (int i = 0; i < 6; i++) begin
      offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h81, 1'b1, 16'h0777, 16'(100 + i)));
    end
    repeat (5) offer_event(spare(lfs_pkg::CMD_TICK));
    // lowered interval wraps on the next accepted packet
    settle();
    write_reg(lfs_pkg::REG_ALIVE, 16'd2);
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h81, 1'b1, 16'h0777, 16'd200));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h81, 1'b1, 16'h0777, 16'd201));
  endtask

  task automatic test_timeout_extremes();
    settle();
    write_reg(lfs_pkg::REG_TIMEOUT, 16'hFFFF);
    offer_event(make_item(lfs_pkg::CMD_CONNECT, 8'h3C, 1'b0, 16'h0000, 16'h0000));
    offer_event(make_item(lfs_pkg::CMD_PACKET, 8'h3C, 1'b1, 16'hABCD, 16'hFFFF));
    repeat (8) offer_event(spare(lfs_pkg::CMD_TICK));
    settle();
    write_reg(lfs_pkg::REG_TIMEOUT, 16'd8);
    repeat (2) offer_event(spare(lfs_pkg::CMD_TICK));
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(lfs_pkg::REG_TIMEOUT, 16'd60000);
    offer_event(make_item(lfs_pkg::CMD_CONNECT, drv_link, 1'b0, 16'h0000, 16'h0000));
    hold_req = 1'b1;
    repeat (40) offer_event(next_traffic());
    settle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(lfs_pkg::REG_TIMEOUT, 16'd1);
          write_reg(lfs_pkg::REG_ALIVE, 16'd1);
        end
        1: begin
          write_reg(lfs_pkg::REG_TIMEOUT, 16'd60000);
          write_reg(lfs_pkg::REG_ALIVE, 16'd255);
        end
        2: begin
          write_reg(lfs_pkg::REG_TIMEOUT, 16'($urandom_range(2, 40)));
          write_reg(lfs_pkg::REG_ALIVE, 16'($urandom_range(2, 12)));
        end
        3: begin
          write_reg(lfs_pkg::REG_TIMEOUT, 16'd0);
          write_reg(lfs_pkg::REG_ALIVE, 16'd0);
        end
        4: begin
          write_reg(lfs_pkg::REG_TIMEOUT, 16'($urandom_range(5, 60)));
          write_reg(lfs_pkg::REG_ALIVE, 16'd3);
        end
        default: begin
          calm = 1'b1;
          write_reg(lfs_pkg::REG_TIMEOUT, 16'($urandom_range(1, 30)));
          write_reg(lfs_pkg::REG_ALIVE, 16'($urandom_range(1, 255)));
        end
      endcase
      offer_event(make_item(lfs_pkg::CMD_CONNECT, drv_link, 1'b0, 16'h0000, 16'h0000));
      repeat (230) begin
        if ($urandom_range(0, 149) == 0) settle();
        offer_event(next_traffic());
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_index <= lfs_pkg::REG_TIMEOUT;
    cfg_wdata <= '0;
    lim_ms = lfs_pkg::TIMEOUT_RST;
    beat_every = lfs_pkg::ALIVE_RST;
    peer_id = 8'd0;
    peer_up = 1'b0;
    sess_now = 16'd0;
    seq_now = 16'd0;
    heard = 1'b0;
    tripped = 1'b0;
    quiet_ms = 16'd0;
    beat_cnt = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_stop_rules();
    test_timeout_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    if (results_due.size() != 0) flag_mismatch("items never returned", results_due.size(), 0);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lfs_pkg.sv
rtl/lfs_core.sv
rtl/link_failsafe_supervisor.sv
rtl/lfs_checker.sv
test/tb.sv
